// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is active.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert a property on the rising clock edge, also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/dtq_pkg.sv
// Package for the drop-tail queue departure model: types, sizes and codes.
`timescale 1ns / 1ps
package dtq_pkg;

  // Departure store geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Field widths
  localparam int TIME_W  = 48;
  localparam int SIZE_W  = 16;
  localparam int BTIME_W = 16;
  localparam int PROD_W  = SIZE_W + BTIME_W;
  localparam int STAT_W  = 32;
  localparam int SUM_W   = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'd1;
  localparam logic [BTIME_W-1:0]   BYTE_TIME_RST    = 16'd727;
  localparam logic [LIMIT_W-1:0]   BUFFER_LIMIT_RST = 7'd50;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [SIZE_W-1:0] packet_size;
  } in_t;

  typedef struct packed {
    logic               dropped;
    logic [TIME_W-1:0]  departure_time;
    logic [TIME_W-1:0]  wait_time;
    logic [LIMIT_W-1:0] occupancy;
    logic [STAT_W-1:0]  packets_seen;
    logic [STAT_W-1:0]  packets_dropped;
    logic [STAT_W-1:0]  packets_delayed;
    logic [SUM_W-1:0]   delay_sum;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PURGE,
    ST_CALC,
    ST_FINISH
  } state_e;

  // Saturating increment of a 32-bit counter
  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (&v) ? v : v + STAT_W'(1);
  endfunction

endpackage

// File: hdl/drop_tail_queue_departure_model_top.sv
// Top level of the drop-tail queue departure model.
// Usage:
//   Pulse start with an arrival on in_i while busy is low; the item transfers
//   at that edge and busy rises. The block first pops every queued departure
//   earlier than the arrival, one pop per cycle through a single read port of
//   the departure memory, then decides drop or push and updates the counters.
//   The result appears on out_o, marked by done_o for one cycle, as busy falls.
//   Sequence: after the accepting edge the purge state pops each departure
//   due, then the calc and finish states run, and done_o is registered from
//   the finish state; each departure is pushed once and popped once.
//   A new item may start in the cycle that done_o is high.
//   Configuration: cfg_we_i writes byte_time (index 0) or buffer_limit
//   (index 1) from cfg_data_i; write only while busy is low.
//   Reset clears the queue, the counters and the sequencer and restores
//   byte_time 727 and buffer_limit 50; memory contents are left as they are,
//   since only written entries are ever read.
//   The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps
module drop_tail_queue_departure_model_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  dtq_pkg::in_t                 in_i,
  output logic                         done_o,
  output dtq_pkg::out_t                out_o,
  input  logic                         cfg_we_i,
  input  logic [dtq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dtq_pkg::*;

  // Departure memory
  logic [TIME_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_addr;
  logic [TIME_W-1:0] rd_data_q;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [TIME_W-1:0] wr_data;

  state_e state_q, state_d;

  logic [BTIME_W-1:0] byte_time_q;
  logic [LIMIT_W-1:0] buffer_limit_q;

  logic [TIME_W-1:0] arr_q, arr_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [TIME_W-1:0] wait_q, wait_d;
  logic [TIME_W-1:0] begin_q, begin_d;
  logic              drop_q, drop_d;
  logic [STAT_W-1:0] seen_q, seen_d;
  logic [STAT_W-1:0] dropcnt_q, dropcnt_d;
  logic [STAT_W-1:0] delayed_q, delayed_d;
  logic [SUM_W-1:0]  total_q, total_d;
  out_t              out_q, out_d;
  logic              done_q, done_d;

  logic [PTR_W-1:0]   head_next;
  logic [CNT_W:0]     tail_sum;
  logic [CMP_W-1:0]   limit_eff;
  logic               pop_now;
  logic [TIME_W:0]    depart_sum;
  logic [TIME_W-1:0]  depart_sat;
  logic [SUM_W:0]     total_sum;
  logic [SUM_W-1:0]   total_sat;

  // Effective limit: never above the memory depth
  always_comb begin
    if (CMP_W'(buffer_limit_q) > CMP_W'(QUEUE_DEPTH)) begin
      limit_eff = CMP_W'(QUEUE_DEPTH);
    end else begin
      limit_eff = CMP_W'(buffer_limit_q);
    end
  end

  // Ring pointer arithmetic
  assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  always_comb begin
    tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(fill_q);
    if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    wr_addr = tail_sum[PTR_W-1:0];
  end

  assign pop_now = (fill_q != '0) && (rd_data_q < arr_q);

  // Departure add and delay accumulate, each saturating
  assign depart_sum = {1'b0, begin_q} + (TIME_W + 1)'(prod_q);
  assign depart_sat = depart_sum[TIME_W] ? '1 : depart_sum[TIME_W-1:0];
  assign total_sum  = {1'b0, total_q} + (SUM_W + 1)'(wait_q);
  assign total_sat  = total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_PURGE;
        end
      end
      ST_PURGE: begin
        if (!pop_now) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC:   state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer
  always_comb begin
    arr_d     = arr_q;
    size_d    = size_q;
    last_d    = last_q;
    head_d    = head_q;
    fill_d    = fill_q;
    prod_d    = prod_q;
    wait_d    = wait_q;
    begin_d   = begin_q;
    drop_d    = drop_q;
    seen_d    = seen_q;
    dropcnt_d = dropcnt_q;
    delayed_d = delayed_q;
    total_d   = total_q;
    out_d     = out_q;
    done_d    = 1'b0;
    rd_addr   = head_q;
    wr_en     = 1'b0;
    wr_data   = depart_sat;
    busy      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          arr_d  = in_i.arrival_time;
          size_d = in_i.packet_size;
        end
      end
      ST_PURGE: begin
        // Drop the head while it departs before this arrival
        if (pop_now) begin
          head_d  = head_next;
          fill_d  = fill_q - CNT_W'(1);
          rd_addr = head_next;
        end
      end
      ST_CALC: begin
        drop_d = (CMP_W'(fill_q) >= limit_eff);
        prod_d = PROD_W'(size_q) * PROD_W'(byte_time_q);
        if ((fill_q != '0) && (last_q > arr_q)) begin
          wait_d  = last_q - arr_q;
          begin_d = last_q;
        end else begin
          wait_d  = '0;
          begin_d = arr_q;
        end
      end
      ST_FINISH: begin
        seen_d = sat_inc(seen_q);
        out_d.dropped        = drop_q;
        out_d.departure_time = '0;
        out_d.wait_time      = '0;
        out_d.occupancy      = LIMIT_W'(fill_q);
        if (drop_q) begin
          dropcnt_d = sat_inc(dropcnt_q);
        end else begin
          // Push the departure and account for the delay
          wr_en  = 1'b1;
          last_d = depart_sat;
          fill_d = fill_q + CNT_W'(1);
          out_d.departure_time = depart_sat;
          out_d.wait_time      = wait_q;
          out_d.occupancy      = LIMIT_W'(fill_q + CNT_W'(1));
          if (fill_q != '0) begin
            delayed_d = sat_inc(delayed_q);
            total_d   = total_sat;
          end
        end
        out_d.packets_seen    = seen_d;
        out_d.packets_dropped = dropcnt_d;
        out_d.packets_delayed = delayed_d;
        out_d.delay_sum       = total_d;
        done_d = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      head_q         <= '0;
      fill_q         <= '0;
      seen_q         <= '0;
      dropcnt_q      <= '0;
      delayed_q      <= '0;
      total_q        <= '0;
      done_q         <= 1'b0;
      byte_time_q    <= BYTE_TIME_RST;
      buffer_limit_q <= BUFFER_LIMIT_RST;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      seen_q    <= seen_d;
      dropcnt_q <= dropcnt_d;
      delayed_q <= delayed_d;
      total_q   <= total_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BYTE_TIME:    byte_time_q    <= BTIME_W'(cfg_data_i);
          CFG_BUFFER_LIMIT: buffer_limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    arr_q   <= arr_d;
    size_q  <= size_d;
    last_q  <= last_d;
    prod_q  <= prod_d;
    wait_q  <= wait_d;
    begin_q <= begin_d;
    drop_q  <= drop_d;
    out_q   <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

// File: hdl/dtq_checker.sv
// Port-level checker for the drop-tail queue departure model, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input dtq_pkg::out_t out_o
);
  import dtq_pkg::*;

  // Result shows only once the sequencer is free again
  `ASSERT_CLK(a_done_not_busy, done_o |-> !busy, "result while busy")
  // An accepted item makes the block busy
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accept without busy")
  // Busy rises only on an accepted transfer
  `ASSERT_CLK(a_busy_rise, $rose(busy) |-> $past(start), "busy without start")
  // A dropped packet carries no departure and no wait
  `ASSERT_CLK(a_drop_zero,
    (done_o && out_o.dropped) |-> (out_o.departure_time == '0 && out_o.wait_time == '0),
    "dropped packet with times")
  // Every result counts at least one arrival
  `ASSERT_CLK(a_seen_nonzero, done_o |-> (out_o.packets_seen != '0), "seen count zero")

endmodule

bind drop_tail_queue_departure_model_top dtq_checker u_dtq_checker (.*);
